FILE: src/skvt_pkg.sv
// Shared request codes, status codes and controller states for the sorted key/value table.
package skvt_pkg;

	localparam logic [1:0] REQ_FIND   = 2'd0;
	localparam logic [1:0] REQ_UPSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_BAD_POS   = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_COMPARE,
		S_SHIFT,
		S_PLACE
	} skvt_state_t;

endpackage

FILE: src/skvt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module skvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/sorted_key_value_table_top.sv
// Sorted key/value table: bisection search, sorted insert and positional remove over one RAM.
// A lookup alternates probe and compare states; an insert adds a shift of the following pairs and a place step,
// a remove shifts the following pairs down, and a bad request is answered without leaving idle.
// One request is in flight at a time; reset clears the pair count and key order, not the RAM.
module sorted_key_value_table_top #(
	parameter int DEPTH       = 32,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic                       cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 req_type,
	input  logic [KEY_WIDTH-1:0]       key,
	input  logic [VALUE_WIDTH-1:0]     new_value,
	input  logic [$clog2(DEPTH)-1:0]   position,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] slot,
	output logic [VALUE_WIDTH-1:0]     stored_value,
	output logic [$clog2(DEPTH+1)-1:0] entries
);

	import skvt_pkg::*;

	// AW indexes the RAM; CW holds a count from zero to DEPTH inclusive.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = KEY_WIDTH + VALUE_WIDTH;
	localparam logic [KEY_WIDTH-1:0] KEY_MSB = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	skvt_state_t state_q, state_d;

	// Control and request registers.
	logic                   signed_q;
	logic [CW-1:0]          count_q;
	logic [1:0]             req_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          lo_q, hi_q;
	logic [AW-1:0]          mid_q;
	logic [CW-1:0]          slot_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          rd_ptr_q;
	logic                   pend_s1;
	logic [AW-1:0]          wr_addr_s1;

	// Result registers; done strobes as each word is finished, and the word holds until a new request is accepted.
	logic                   done_q;
	logic [2:0]             status_q;
	logic [CW-1:0]          res_slot_q;
	logic [VALUE_WIDTH-1:0] res_value_q;

	// RAM port signals. Each entry holds a key in the upper bits and its value below.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [PW-1:0] ram_wdata, ram_rdata;

	logic                   accept;
	logic [CW:0]            mid_sum;
	logic [AW-1:0]          mid;
	logic                   probe_live;
	logic [KEY_WIDTH-1:0]   have, want;
	logic                   key_eq, key_lt;
	logic                   pos_ok;
	logic                   shift_end;
	logic [VALUE_WIDTH-1:0] rd_value;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Bisection midpoint over the half-open interval [lo, hi).
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[AW:1];
	assign probe_live = (lo_q < hi_q);

	// Flipping the sign bit makes an unsigned compare follow two's complement order.
	assign have     = ram_rdata[PW-1:VALUE_WIDTH] ^ (signed_q ? KEY_MSB : '0);
	assign want     = key_q ^ (signed_q ? KEY_MSB : '0);
	assign key_eq   = (have == want);
	assign key_lt   = (have < want);
	assign rd_value = ram_rdata[VALUE_WIDTH-1:0];

	assign pos_ok    = ({{(CW-AW){1'b0}}, position} < count_q);
	assign shift_end = (cnt_q == '0) && !pend_s1;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_FIND || req_type == REQ_UPSERT) begin
						state_d = S_PROBE;
					end else if (req_type == REQ_REMOVE && pos_ok) begin
						state_d = S_SHIFT;
					end
				end
			end
			S_PROBE: begin
				if (probe_live) begin
					state_d = S_COMPARE;
				end else if (req_q == REQ_UPSERT && count_q != FULL_COUNT) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_COMPARE: begin
				state_d = key_eq ? S_IDLE : S_PROBE;
			end
			S_SHIFT: begin
				if (shift_end) begin
					state_d = (req_q == REQ_UPSERT) ? S_PLACE : S_IDLE;
				end
			end
			S_PLACE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// RAM access control. During a shift, the word read last cycle is written to its
	// neighbor while the next one is read; the two addresses never coincide.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		case (state_q)
			S_PROBE: begin
				ram_re    = probe_live;
				ram_raddr = mid;
			end
			S_COMPARE: begin
				ram_we    = key_eq && (req_q == REQ_UPSERT);
				ram_waddr = mid_q;
				ram_wdata = {key_q, val_q};
			end
			S_SHIFT: begin
				ram_we = pend_s1;
				ram_re = (cnt_q != '0);
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q[AW-1:0];
				ram_wdata = {key_q, val_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	skvt_ram #(
		.WIDTH(PW),
		.DEPTH(DEPTH)
	) u_pairs (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			signed_q <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_write) begin
				signed_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept && !(req_type == REQ_FIND || req_type == REQ_UPSERT)
						&& !(req_type == REQ_REMOVE && pos_ok)) begin
						done_q <= 1'b1;
					end
				end
				S_PROBE: begin
					pend_s1 <= 1'b0;
					if (!probe_live && !(req_q == REQ_UPSERT && count_q != FULL_COUNT)) begin
						done_q <= 1'b1;
					end
				end
				S_COMPARE: begin
					if (key_eq) begin
						done_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					pend_s1 <= (cnt_q != '0);
					if (shift_end && req_q != REQ_UPSERT) begin
						done_q  <= 1'b1;
						count_q <= count_q - CW'(1);
					end
				end
				S_PLACE: begin
					done_q  <= 1'b1;
					count_q <= count_q + CW'(1);
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Request datapath and result words; these need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q       <= req_type;
					key_q       <= key;
					val_q       <= new_value;
					lo_q        <= '0;
					hi_q        <= count_q;
					cnt_q       <= count_q - CW'(1) - {{(CW-AW){1'b0}}, position};
					rd_ptr_q    <= AW'({{(CW-AW){1'b0}}, position} + CW'(1));
					slot_q      <= {{(CW-AW){1'b0}}, position};
					status_q    <= ST_BAD_POS;
					res_slot_q  <= (req_type == REQ_REMOVE) ?
						{{(CW-AW){1'b0}}, position} : '0;
					res_value_q <= '0;
				end
			end
			S_PROBE: begin
				mid_q <= mid;
				if (!probe_live) begin
					res_slot_q  <= lo_q;
					slot_q      <= lo_q;
					res_value_q <= '0;
					cnt_q       <= count_q - lo_q;
					rd_ptr_q    <= AW'(count_q - CW'(1));
					if (req_q == REQ_FIND) begin
						status_q <= ST_NOT_FOUND;
					end else if (count_q == FULL_COUNT) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_INSERTED;
					end
				end
			end
			S_COMPARE: begin
				if (key_eq) begin
					status_q    <= ST_FOUND;
					res_slot_q  <= {{(CW-AW){1'b0}}, mid_q};
					res_value_q <= (req_q == REQ_FIND) ? rd_value : '0;
				end else if (key_lt) begin
					lo_q <= {{(CW-AW){1'b0}}, mid_q} + CW'(1);
				end else begin
					hi_q <= {{(CW-AW){1'b0}}, mid_q};
				end
			end
			S_SHIFT: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
					// An insert walks down and moves words up; a remove does the opposite.
					if (req_q == REQ_UPSERT) begin
						wr_addr_s1 <= rd_ptr_q + AW'(1);
						rd_ptr_q   <= rd_ptr_q - AW'(1);
					end else begin
						wr_addr_s1 <= rd_ptr_q - AW'(1);
						rd_ptr_q   <= rd_ptr_q + AW'(1);
					end
				end
				if (shift_end && req_q != REQ_UPSERT) begin
					status_q    <= ST_REMOVED;
					res_value_q <= '0;
				end
			end
			default: begin
				res_value_q <= res_value_q;
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot         = res_slot_q;
	assign stored_value = res_value_q;
	assign entries      = count_q;

endmodule

FILE: dv/tb_sorted_key_value_table_top.sv
// Testbench for the sorted key/value table: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_sorted_key_value_table_top;
	import skvt_pkg::*;

	// The block is built with its default sizes: 32 pairs of 32-bit keys and values.
	localparam int TBL_DEPTH     = 32;
	localparam int RANDOM_ITEMS  = 1200;
	// A slow request is a full bisection plus a full shift; with long sender gaps as well,
	// a correct run still stays far below this limit.
	localparam int CYCLE_LIMIT   = 600000;
	// Worst single request latency with some margin; used after the last result.
	localparam int DRAIN_CYCLES  = 80;
	// The one request code the block does not define; it is answered as a bad request.
	localparam logic [1:0] REQ_IGNORED = 2'd3;

	// One result word as the block should present it.
	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [31:0] value;
		logic [5:0]  entries;
	} kv_result_t;

	// Scoreboard: keeps its own copy of the pair table and the key order, works out
	// the result word of each accepted request, and checks result words in order.
	class kv_scoreboard;
		logic [31:0] key_tbl[TBL_DEPTH];
		logic [31:0] value_tbl[TBL_DEPTH];
		int unsigned count = 0;
		int unsigned peak = 0;
		bit          signed_mode = 0;
		kv_result_t  expected_q[$];
		int          errors = 0;
		int          status_seen[6] = '{default: 0};

		// Maps a key onto an unsigned number whose order matches the selected order.
		function logic [31:0] order_key(logic [31:0] k);
			return signed_mode ? (k ^ 32'h8000_0000) : k;
		endfunction

		// Bisection over the occupied part; the first probe that equals the key wins.
		function bit bisect(logic [31:0] k, output int unsigned where);
			int unsigned lo, hi, mid;
			logic [31:0] want, have;
			lo = 0;
			hi = count;
			want = order_key(k);
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				have = order_key(key_tbl[mid]);
				if (have < want) begin
					lo = mid + 1;
				end else if (have > want) begin
					hi = mid;
				end else begin
					where = mid;
					return 1'b1;
				end
			end
			where = lo;
			return 1'b0;
		endfunction

		function void note_request(logic [1:0] req, logic [31:0] k, logic [31:0] v,
				logic [4:0] p);
			kv_result_t  r;
			int unsigned where, i;
			bit          hit;
			r.status = ST_BAD_POS;
			r.slot   = '0;
			r.value  = '0;
			case (req)
				REQ_FIND: begin
					hit = bisect(k, where);
					r.slot = where[5:0];
					if (hit) begin
						r.status = ST_FOUND;
						r.value  = value_tbl[where];
					end else begin
						r.status = ST_NOT_FOUND;
					end
				end
				REQ_UPSERT: begin
					hit = bisect(k, where);
					r.slot = where[5:0];
					if (hit) begin
						value_tbl[where] = v;
						r.status = ST_FOUND;
					end else if (count >= TBL_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (i = count; i > where; i--) begin
							key_tbl[i]   = key_tbl[i-1];
							value_tbl[i] = value_tbl[i-1];
						end
						key_tbl[where]   = k;
						value_tbl[where] = v;
						count++;
						r.status = ST_INSERTED;
					end
				end
				REQ_REMOVE: begin
					r.slot = {1'b0, p};
					if (p < count) begin
						for (i = p; i + 1 < count; i++) begin
							key_tbl[i]   = key_tbl[i+1];
							value_tbl[i] = value_tbl[i+1];
						end
						count--;
						r.status = ST_REMOVED;
					end
				end
				default: begin
					// Unused request code: the table is left alone.
				end
			endcase
			if (count > peak)
				peak = count;
			r.entries = count[5:0];
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] st, logic [5:0] sl, logic [31:0] val,
				logic [5:0] ent);
			kv_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: status %0h slot %0h value %0h entries %0h",
					$time, st, sl, val, ent);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("status", e.status, st);
			compare_field("slot", e.slot, sl);
			compare_field("stored_value", e.value, val);
			compare_field("entries", e.entries, ent);
			if (e.status <= ST_BAD_POS)
				status_seen[e.status]++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [31:0] key;
	logic [31:0] new_value;
	logic [4:0]  position;
	logic        done;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [31:0] stored_value;
	logic [5:0]  entries;

	kv_scoreboard sb;
	int           cycle_count = 0;
	int           request_words = 0;
	int           random_words = 0;
	int           cfg_writes = 0;

	sorted_key_value_table_top #(
		.DEPTH(TBL_DEPTH),
		.KEY_WIDTH(32),
		.VALUE_WIDTH(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.new_value(new_value),
		.position(position),
		.done(done),
		.status(status),
		.slot(slot),
		.stored_value(stored_value),
		.entries(entries)
	);

	always #10 clk = ~clk;

	// Result words are accepted at the edge that ends their strobe cycle; the values
	// read here are the ones from before the edge, so the order of processes does not matter.
	always @(posedge clk) begin
		if (done)
			sb.check_result(status, slot, stored_value, entries);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d result words outstanding",
				cycle_count, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Presents one request word and holds it until the block takes it. The word is
	// taken at an edge where start is high and busy was low just before the edge.
	// Start stays high on return so that a following word can go out back to back.
	task automatic send_request(logic [1:0] req, logic [31:0] k, logic [31:0] v,
			logic [4:0] p);
		start     <= 1'b1;
		req_type  <= req;
		key       <= k;
		new_value <= v;
		position  <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(req, k, v, p);
		request_words++;
	endtask

	// Sender gap. Start is only lowered here when time moves on afterwards, so it never
	// sees a low and a high assignment in the same step.
	task automatic idle_cycles(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Holds off the sender until every result word has come back and the block is idle.
	// Start is high only right after a word was taken, so the loop always runs then.
	task automatic wait_idle();
		if (start)
			start <= 1'b0;
		while (sb.pending() != 0 || busy)
			@(posedge clk);
	endtask

	// Changes the key order. The register is only written while nothing is in flight.
	task automatic write_key_order(bit mode);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		sb.signed_mode = mode;
		cfg_writes++;
		cfg_write <= 1'b0;
	endtask

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Keys are drawn from the table itself (hits and updates), from its neighbors
	// (insertion points right beside stored keys), from the order boundaries, or at random.
	function automatic logic [31:0] pick_key();
		int          r;
		logic [31:0] edge_keys[6];
		edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE};
		r = $urandom_range(0, 99);
		if (sb.count > 0 && r < 40)
			return sb.key_tbl[$urandom_range(0, sb.count - 1)];
		if (sb.count > 0 && r < 52)
			return sb.key_tbl[$urandom_range(0, sb.count - 1)]
				+ (($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF);
		if (r < 64)
			return edge_keys[$urandom_range(0, 5)];
		return $urandom();
	endfunction

	// Mostly positions of stored pairs, the rest anywhere in the 5-bit range.
	function automatic logic [4:0] pick_position();
		if (sb.count > 0 && $urandom_range(0, 99) < 80)
			return 5'($urandom_range(0, sb.count - 1));
		return 5'($urandom_range(0, 31));
	endfunction

	initial begin
		int  flavor, burst, len, hold_at, r, j;
		int  t_find, t_up, t_rem;
		logic [1:0] req;

		sb = new();
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_data  <= 1'b0;
		start     <= 1'b0;
		req_type  <= REQ_FIND;
		key       <= '0;
		new_value <= '0;
		position  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Unsigned order first, on an empty table.
		write_key_order(1'b0);
		send_request(REQ_FIND, 32'h0000_0000, 32'h0, 5'd0);
		send_request(REQ_REMOVE, 32'h0, 32'h0, 5'd0);
		send_request(REQ_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
		send_request(REQ_UPSERT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
		send_request(REQ_UPSERT, 32'hFFFF_FFFF, 32'h0000_0000, 5'd31);
		send_request(REQ_UPSERT, 32'h8000_0000, 32'hA5A5_A5A5, 5'd0);
		send_request(REQ_UPSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 5'd0);
		send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 5'd0);
		send_request(REQ_FIND, 32'h0000_0001, 32'h0, 5'd0);
		send_request(REQ_UPSERT, 32'h8000_0000, 32'h0000_1234, 5'd0);
		send_request(REQ_FIND, 32'h8000_0000, 32'h0, 5'd0);

		// Switch to signed order with the table filled under unsigned order: the
		// stored order is no longer sorted and bisection runs over it as it is.
		write_key_order(1'b1);
		send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 5'd0);
		send_request(REQ_FIND, 32'h8000_0000, 32'h0, 5'd0);
		send_request(REQ_UPSERT, 32'hC000_0000, $urandom(), 5'd0);
		send_request(REQ_FIND, 32'h0000_0000, 32'h0, 5'd0);
		send_request(REQ_REMOVE, 32'h0, 32'h0, 5'd31);
		send_request(REQ_REMOVE, 32'h0, 32'h0, 5'd0);
		send_request(REQ_REMOVE, 32'h0, 32'h0, 5'(sb.count - 1));
		send_request(REQ_IGNORED, $urandom(), $urandom(), 5'($urandom_range(0, 31)));
		send_request(REQ_FIND, 32'h7FFF_FFFF, 32'h0, 5'd0);

		// Random part, in phases. Each phase may change the key order with pairs still
		// stored and leans toward filling, draining, looking up, or a mix; fill phases
		// lean hard on upserts, so the table can reach its full state and see upserts there.
		while (random_words < RANDOM_ITEMS) begin
			write_key_order(1'($urandom_range(0, 1)));
			flavor  = $urandom_range(0, 3);
			burst   = ($urandom_range(0, 3) == 0);
			len     = $urandom_range(40, 80);
			hold_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : -1;
			case (flavor)
				0: begin t_find = 15; t_up = 90; t_rem = 97; end
				1: begin t_find = 22; t_up = 32; t_rem = 97; end
				2: begin t_find = 60; t_up = 80; t_rem = 97; end
				default: begin t_find = 34; t_up = 68; t_rem = 97; end
			endcase
			for (j = 0; j < len && random_words < RANDOM_ITEMS; j++) begin
				r = $urandom_range(0, 99);
				if (r < t_find)
					req = REQ_FIND;
				else if (r < t_up)
					req = REQ_UPSERT;
				else if (r < t_rem)
					req = REQ_REMOVE;
				else
					req = REQ_IGNORED;
				send_request(req, pick_key(), $urandom(), pick_position());
				if (req != REQ_IGNORED)
					random_words++;
				if (!burst)
					idle_cycles(draw_gap());
				// Now and then the sender stops until every result word is back.
				if (j == hold_at)
					wait_idle();
			end
		end

		// Let the last result word arrive, then give the block time to show anything stray.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d request words under %0d key order writes; table peaked at %0d of %0d pairs",
			request_words, cfg_writes, sb.peak, TBL_DEPTH);
		$display("Results: %0d found/updated, %0d missed, %0d inserted, %0d full, %0d removed, %0d rejected",
			sb.status_seen[ST_FOUND], sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_INSERTED],
			sb.status_seen[ST_FULL], sb.status_seen[ST_REMOVED], sb.status_seen[ST_BAD_POS]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d result words never arrived", sb.errors, sb.pending());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
